### design/qnl_pkg.sv
// shared constants, types and helpers for the quaternion nlerp pipeline
package qnl_pkg;

    localparam int BLEND_W    = 17;
    localparam logic [BLEND_W-1:0] ONE_Q16 = 17'h10000;
    localparam int NORM_W     = 32;
    localparam int SQ_W       = 64;
    localparam int SQRT_STEPS = 32;
    localparam int SHIFT_W    = 6;

    typedef logic [BLEND_W-1:0] blend_t;
    typedef logic [NORM_W-1:0]  norm_mag_t;
    typedef logic [SQ_W-1:0]    sq_t;
    typedef logic [SHIFT_W-1:0] shift_t;

    // leading zero count, all zeros gives NORM_W
    function automatic shift_t lead_zeros(input norm_mag_t v);
        shift_t n;
        logic   found;
        n     = shift_t'(NORM_W);
        found = 1'b0;
        for (int i = NORM_W - 1; i >= 0; i--)
        begin
            if (!found && v[i])
            begin
                n     = shift_t'(NORM_W - 1 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

endpackage

### design/quaternion_nlerp.sv
// quaternion nlerp top level: stream ports and the pipeline segments
//
// channel  dir  signals                 payload
// s        in   s_tvalid/s_tready       s_tdata: a_w a_x a_y a_z b_w b_x b_y b_z blend
// m        out  m_tvalid/m_tready       m_tdata: out_w out_x out_y out_z, m_tuser: zero_norm
//
// one beat in per cycle, one beat out per cycle at full throughput, while m does not stall
// the pipeline has 3 weighting stages, 5 scaling stages, 32 square root stages and
//   COMP_WIDTH + 4 divider stages
// the 32-step root and the one-bit-per-stage divider set the depth
// reset clears only the valid bits; data registers are left as they are
// a stall on m freezes every stage at once, so nothing is dropped or repeated
module quaternion_nlerp import qnl_pkg::*; #(
    parameter int COMP_WIDTH = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, blend, zero pad
    input  logic [((8*COMP_WIDTH+BLEND_W+7)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // out_w, out_x, out_y, out_z, zero pad
    output logic [((4*COMP_WIDTH+7)/8)*8-1:0] m_tdata,
    // zero_norm
    output logic m_tuser
);

    localparam int W      = COMP_WIDTH;
    localparam int MW     = W + 16;
    localparam int OUT_W  = ((4 * W + 7) / 8) * 8;
    localparam int SIDE_W = 4 * NORM_W + 5;

    // one enable for all stages: move whenever the output slot is free or drains
    logic ce;
    assign ce       = !m_tvalid || m_tready;
    assign s_tready = ce;

    // weighting
    logic              f_valid;
    logic [MW-1:0]     f_mx;
    logic [4*MW-1:0]   f_mags;
    logic [3:0]        f_neg;
    logic              f_zero;

    qnl_front #(.W(W)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (s_tvalid),
        .a_q       (s_tdata[4*W-1:0]),
        .b_q       (s_tdata[8*W-1:4*W]),
        .blend     (s_tdata[8*W +: BLEND_W]),
        .out_valid (f_valid),
        .mx        (f_mx),
        .mags      (f_mags),
        .neg       (f_neg),
        .zero      (f_zero)
    );

    // scaling and sum of squares
    logic                n_valid;
    sq_t                 n_q;
    logic [4*NORM_W-1:0] n_mags;
    logic [3:0]          n_neg;
    logic                n_zero;

    qnl_norm #(.W(W)) u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (f_valid),
        .mx        (f_mx),
        .mags      (f_mags),
        .neg       (f_neg),
        .zero      (f_zero),
        .out_valid (n_valid),
        .qsum      (n_q),
        .nmags     (n_mags),
        .out_neg   (n_neg),
        .out_zero  (n_zero)
    );

    // root, with magnitudes, signs and the zero flag riding alongside
    logic              r_valid;
    norm_mag_t         r_root;
    logic [SIDE_W-1:0] r_side;

    qnl_sqrt #(.SIDE_W(SIDE_W)) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (n_valid),
        .q         (n_q),
        .side_in   ({n_zero, n_neg, n_mags}),
        .out_valid (r_valid),
        .root      (r_root),
        .side_out  (r_side)
    );

    // division and output register
    logic [4*W-1:0] d_comps;

    qnl_div #(.W(W)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (r_valid),
        .root      (r_root),
        .nmags     (r_side[4*NORM_W-1:0]),
        .neg       (r_side[4*NORM_W +: 4]),
        .zero      (r_side[SIDE_W-1]),
        .out_valid (m_tvalid),
        .comps     (d_comps),
        .zero_out  (m_tuser)
    );

    assign m_tdata = OUT_W'(d_comps);

`ifndef SYNTHESIS
    // a zero norm beat carries all-zero components
    a_zero_clears: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("zero norm beat with nonzero components");

    // a normalized result is never all zero
    a_unit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata != '0)
        else $error("normalized beat came out all zero");
`endif

endmodule

### design/qnl_front.sv
// weighting front end: products, dot sign, blended magnitudes and their maximum
module qnl_front import qnl_pkg::*; #(
    parameter int W = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              ce,
    input  logic              in_valid,
    input  logic [4*W-1:0]    a_q,
    input  logic [4*W-1:0]    b_q,
    input  blend_t            blend,
    output logic              out_valid,
    output logic [W+15:0]     mx,
    output logic [4*(W+16)-1:0] mags,
    output logic [3:0]        neg,
    output logic              zero
);

    localparam int MW = W + 16;
    localparam int PW = 2 * W;
    localparam int KW = W + 18;
    localparam int DW = PW + 2;

    blend_t t_c;
    blend_t k0;
    logic signed [PW-1:0] pab_next [4];
    logic signed [KW-1:0] pa_next  [4];
    logic signed [KW-1:0] pb_next  [4];
    logic signed [PW-1:0] pab_reg  [4];
    logic signed [KW-1:0] pa_reg   [4];
    logic signed [KW-1:0] pb_reg   [4];
    logic                 v1_reg;

    assign t_c = (blend > ONE_Q16) ? ONE_Q16 : blend;
    assign k0  = ONE_Q16 - t_c;

    // stage 1: all multiplies
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            pab_next[i] = $signed(a_q[i*W +: W]) * $signed(b_q[i*W +: W]);
            pa_next[i]  = $signed(a_q[i*W +: W]) * $signed({1'b0, k0});
            pb_next[i]  = $signed(b_q[i*W +: W]) * $signed({1'b0, t_c});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (ce)
            v1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            pab_reg <= pab_next;
            pa_reg  <= pa_next;
            pb_reg  <= pb_next;
        end
    end

    // stage 2: dot sign, blend, magnitude
    logic signed [DW-1:0] dot;
    logic                 pos;
    logic signed [KW-1:0] s [4];
    logic [MW-1:0]        mag_next [4];
    logic [3:0]           neg_next;
    logic [MW-1:0]        mag2_reg [4];
    logic [3:0]           neg2_reg;
    logic                 v2_reg;

    always_comb
    begin
        dot = '0;
        for (int i = 0; i < 4; i++)
            dot = dot + DW'(pab_reg[i]);
        pos = !dot[DW-1] && (dot != '0);
        for (int i = 0; i < 4; i++)
        begin
            s[i]        = pos ? (pa_reg[i] + pb_reg[i]) : (pa_reg[i] - pb_reg[i]);
            neg_next[i] = s[i][KW-1];
            mag_next[i] = neg_next[i] ? MW'(-s[i]) : MW'(s[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (ce)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            mag2_reg <= mag_next;
            neg2_reg <= neg_next;
        end
    end

    // stage 3: maximum magnitude
    logic [MW-1:0] m01;
    logic [MW-1:0] m23;
    logic [MW-1:0] mx_next;
    logic [MW-1:0] mx_reg;
    logic [MW-1:0] mag3_reg [4];
    logic [3:0]    neg3_reg;
    logic          zero_reg;
    logic          v3_reg;

    assign m01     = (mag2_reg[0] > mag2_reg[1]) ? mag2_reg[0] : mag2_reg[1];
    assign m23     = (mag2_reg[2] > mag2_reg[3]) ? mag2_reg[2] : mag2_reg[3];
    assign mx_next = (m01 > m23) ? m01 : m23;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (ce)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            mx_reg   <= mx_next;
            mag3_reg <= mag2_reg;
            neg3_reg <= neg2_reg;
            zero_reg <= (mx_next == '0);
        end
    end

    assign out_valid = v3_reg;
    assign mx        = mx_reg;
    assign neg       = neg3_reg;
    assign zero      = zero_reg;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
            mags[i*MW +: MW] = mag3_reg[i];
    end

endmodule

### design/qnl_norm.sv
// scales the magnitudes to a fixed range and forms the quarter sum of squares
module qnl_norm import qnl_pkg::*; #(
    parameter int W = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                ce,
    input  logic                in_valid,
    input  logic [W+15:0]       mx,
    input  logic [4*(W+16)-1:0] mags,
    input  logic [3:0]          neg,
    input  logic                zero,
    output logic                out_valid,
    output sq_t                 qsum,
    output logic [4*NORM_W-1:0] nmags,
    output logic [3:0]          out_neg,
    output logic                out_zero
);

    localparam int MW   = W + 16;
    localparam int XW   = (MW > NORM_W + 1) ? MW : NORM_W + 1;
    localparam int KMAX = (MW > NORM_W) ? MW - NORM_W : 0;
    localparam logic [XW-1:0] TOPV = XW'(1) << (NORM_W - 1);

    // stage 4: right shift count
    logic [XW-1:0] mx_x;
    shift_t        k_next;
    shift_t        k_reg;
    logic [MW-1:0] mx4_reg;
    logic [MW-1:0] mag4_reg [4];
    logic [3:0]    neg4_reg;
    logic          zero4_reg;
    logic          v4_reg;

    assign mx_x = XW'(mx);

    always_comb
    begin
        k_next = '0;
        for (int kk = 0; kk <= KMAX; kk++)
        begin
            if ((mx_x >> kk) > TOPV)
                k_next = k_next + shift_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else if (ce)
            v4_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            k_reg     <= k_next;
            mx4_reg   <= mx;
            neg4_reg  <= neg;
            zero4_reg <= zero;
            for (int i = 0; i < 4; i++)
                mag4_reg[i] <= mags[i*MW +: MW];
        end
    end

    // stage 5: apply right shift, find left shift
    norm_mag_t mxs;
    shift_t    l_next;
    shift_t    l_reg;
    norm_mag_t mag5_reg [4];
    logic [3:0] neg5_reg;
    logic      zero5_reg;
    logic      v5_reg;

    assign mxs    = NORM_W'(XW'(mx4_reg) >> k_reg);
    assign l_next = lead_zeros(mxs - norm_mag_t'(1)) - shift_t'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v5_reg <= 1'b0;
        else if (ce)
            v5_reg <= v4_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            l_reg     <= l_next;
            neg5_reg  <= neg4_reg;
            zero5_reg <= zero4_reg;
            for (int i = 0; i < 4; i++)
                mag5_reg[i] <= NORM_W'(XW'(mag4_reg[i]) >> k_reg);
        end
    end

    // stage 6: left shift
    norm_mag_t  mag6_reg [4];
    logic [3:0] neg6_reg;
    logic       zero6_reg;
    logic       v6_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v6_reg <= 1'b0;
        else if (ce)
            v6_reg <= v5_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            neg6_reg  <= neg5_reg;
            zero6_reg <= zero5_reg;
            for (int i = 0; i < 4; i++)
                mag6_reg[i] <= mag5_reg[i] << l_reg;
        end
    end

    // stage 7: squares
    logic [2*NORM_W-1:0] sq_p [4];
    sq_t        sq7_reg  [4];
    norm_mag_t  mag7_reg [4];
    logic [3:0] neg7_reg;
    logic       zero7_reg;
    logic       v7_reg;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
            sq_p[i] = mag6_reg[i] * mag6_reg[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v7_reg <= 1'b0;
        else if (ce)
            v7_reg <= v6_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            mag7_reg  <= mag6_reg;
            neg7_reg  <= neg6_reg;
            zero7_reg <= zero6_reg;
            for (int i = 0; i < 4; i++)
                sq7_reg[i] <= SQ_W'(sq_p[i]) >> 2;
        end
    end

    // stage 8: sum
    sq_t        q8_reg;
    norm_mag_t  mag8_reg [4];
    logic [3:0] neg8_reg;
    logic       zero8_reg;
    logic       v8_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v8_reg <= 1'b0;
        else if (ce)
            v8_reg <= v7_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            q8_reg    <= (sq7_reg[0] + sq7_reg[1]) + (sq7_reg[2] + sq7_reg[3]);
            mag8_reg  <= mag7_reg;
            neg8_reg  <= neg7_reg;
            zero8_reg <= zero7_reg;
        end
    end

    assign out_valid = v8_reg;
    assign qsum      = q8_reg;
    assign out_neg   = neg8_reg;
    assign out_zero  = zero8_reg;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
            nmags[i*NORM_W +: NORM_W] = mag8_reg[i];
    end

endmodule

### design/qnl_sqrt.sv
// pipelined integer square root, one result bit per stage, with side data
module qnl_sqrt import qnl_pkg::*; #(
    parameter int SIDE_W = 133
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              ce,
    input  logic              in_valid,
    input  sq_t               q,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output norm_mag_t         root,
    output logic [SIDE_W-1:0] side_out
);

    sq_t               v_reg    [SQRT_STEPS];
    sq_t               res_reg  [SQRT_STEPS];
    logic [SIDE_W-1:0] side_reg [SQRT_STEPS];
    logic [SQRT_STEPS-1:0] vld_reg;

    for (genvar g = 0; g < SQRT_STEPS; g++)
    begin : g_step
        localparam sq_t BITV = sq_t'(1) << (SQ_W - 2 - 2 * g);
        sq_t               v_in;
        sq_t               res_in;
        logic [SIDE_W-1:0] sd_in;
        logic              vl_in;
        sq_t               trial;
        sq_t               v_nx;
        sq_t               r_nx;

        if (g == 0)
        begin : g_first
            assign v_in   = q;
            assign res_in = '0;
            assign sd_in  = side_in;
            assign vl_in  = in_valid;
        end
        else
        begin : g_rest
            assign v_in   = v_reg[g-1];
            assign res_in = res_reg[g-1];
            assign sd_in  = side_reg[g-1];
            assign vl_in  = vld_reg[g-1];
        end

        always_comb
        begin
            trial = res_in + BITV;
            if (v_in >= trial)
            begin
                v_nx = v_in - trial;
                r_nx = (res_in >> 1) + BITV;
            end
            else
            begin
                v_nx = v_in;
                r_nx = res_in >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[g] <= 1'b0;
            else if (ce)
                vld_reg[g] <= vl_in;
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                v_reg[g]    <= v_nx;
                res_reg[g]  <= r_nx;
                side_reg[g] <= sd_in;
            end
        end
    end

    assign out_valid = vld_reg[SQRT_STEPS-1];
    assign root      = res_reg[SQRT_STEPS-1][NORM_W-1:0];
    assign side_out  = side_reg[SQRT_STEPS-1];

endmodule

### design/qnl_div.sv
// four-lane pipelined restoring divider with rounding, sign and saturation
module qnl_div import qnl_pkg::*; #(
    parameter int W = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                ce,
    input  logic                in_valid,
    input  norm_mag_t           root,
    input  logic [4*NORM_W-1:0] nmags,
    input  logic [3:0]          neg,
    input  logic                zero,
    output logic                out_valid,
    output logic [4*W-1:0]      comps,
    output logic                zero_out
);

    localparam int QB = W + 2;
    localparam int NW = W + 31;
    localparam int DW = W + 34;
    localparam logic [QB-1:0] OM_CAP = QB'(1) << (W - 1);
    localparam logic [QB-1:0] POS_MAX = OM_CAP - QB'(1);

    // prep stage: rounded numerators
    logic [NW-1:0] rem_reg [QB+1][4];
    logic [QB-1:0] q_reg   [QB+1][4];
    norm_mag_t     d_reg   [QB+1];
    logic [3:0]    neg_reg [QB+1];
    logic [QB:0]   zero_reg;
    logic [QB:0]   vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (ce)
            vld_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            d_reg[0]    <= root;
            neg_reg[0]  <= neg;
            zero_reg[0] <= zero;
            for (int i = 0; i < 4; i++)
            begin
                rem_reg[0][i] <= (NW'(nmags[i*NORM_W +: NORM_W]) << (W - 2))
                                 + NW'(root >> 1);
                q_reg[0][i]   <= '0;
            end
        end
    end

    for (genvar g = 0; g < QB; g++)
    begin : g_step
        localparam int J = QB - 1 - g;
        logic [DW-1:0] dsh;
        logic [NW-1:0] rem_nx [4];
        logic [QB-1:0] q_nx   [4];

        assign dsh = DW'(d_reg[g]) << J;

        always_comb
        begin
            for (int i = 0; i < 4; i++)
            begin
                if (DW'(rem_reg[g][i]) >= dsh)
                begin
                    rem_nx[i] = NW'(DW'(rem_reg[g][i]) - dsh);
                    q_nx[i]   = {q_reg[g][i][QB-2:0], 1'b1};
                end
                else
                begin
                    rem_nx[i] = rem_reg[g][i];
                    q_nx[i]   = {q_reg[g][i][QB-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[g+1] <= 1'b0;
            else if (ce)
                vld_reg[g+1] <= vld_reg[g];
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                rem_reg[g+1]  <= rem_nx;
                q_reg[g+1]    <= q_nx;
                d_reg[g+1]    <= d_reg[g];
                neg_reg[g+1]  <= neg_reg[g];
                zero_reg[g+1] <= zero_reg[g];
            end
        end
    end

    // output stage: cap, sign, saturate
    logic [QB-1:0]     om   [4];
    logic [W-1:0]      c_nx [4];
    logic [4*W-1:0]    comps_reg;
    logic              zout_reg;
    logic              vout_reg;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            om[i] = (q_reg[QB][i] > OM_CAP) ? OM_CAP : q_reg[QB][i];
            if (zero_reg[QB])
                c_nx[i] = '0;
            else if (neg_reg[QB][i])
                c_nx[i] = W'(-om[i]);
            else if (om[i] > POS_MAX)
                c_nx[i] = W'(POS_MAX);
            else
                c_nx[i] = W'(om[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vout_reg <= 1'b0;
        else if (ce)
            vout_reg <= vld_reg[QB];
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            zout_reg <= zero_reg[QB];
            for (int i = 0; i < 4; i++)
                comps_reg[i*W +: W] <= c_nx[i];
        end
    end

    assign out_valid = vout_reg;
    assign comps     = comps_reg;
    assign zero_out  = zout_reg;

endmodule

### tb/sv/quaternion_nlerp_tb.sv
// self-checking stream testbench for the quaternion nlerp block
module quaternion_nlerp_tb;
    import qnl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW     = 16;
    localparam int IN_W   = ((8*CW+BLEND_W+7)/8)*8;
    localparam int OUT_W  = ((4*CW+7)/8)*8;
    localparam int LAT    = CW + 44;

    typedef logic signed [CW-1:0] comp_t;

    typedef struct packed {
        comp_t w;
        comp_t x;
        comp_t y;
        comp_t z;
        logic  zero_norm;
    } blend_out_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [IN_W-1:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [OUT_W-1:0] m_tdata;
    logic m_tuser;

    quaternion_nlerp #(.COMP_WIDTH(CW)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    blend_out_t pending_blends[$];
    int         errors;
    bit         send_gaps;      // random idling on the input side
    bit         recv_gaps;      // random stalls on the output side
    int         hold_off;       // cycles the receiver must still hold m_tready low

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // hard limit on the whole run
    initial
    begin
        #4000000;
        $display("FAIL quaternion_nlerp");
        $finish;
    end

    // integer square root, floor
    function automatic logic [63:0] root_floor(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // expected normalized blend of one input beat
    function automatic blend_out_t predict_nlerp(input comp_t qa[4], input comp_t qb[4],
                                                 input logic [BLEND_W-1:0] t_raw);
        blend_out_t       o;
        logic signed [63:0] dotp;
        logic signed [63:0] k0, k1, s;
        logic [63:0]      mag[4];
        logic             neg[4];
        logic [63:0]      mx, q, r, om, t;
        logic signed [63:0] v;
        comp_t            res[4];
        dotp = 0;
        for (int i = 0; i < 4; i++)
            dotp += 64'(qa[i]) * 64'(qb[i]);
        t  = (t_raw > ONE_Q16) ? 64'(ONE_Q16) : 64'(t_raw);
        k0 = 64'(ONE_Q16) - t;
        // zero dot counts as not positive
        k1 = (dotp > 0) ? t : -t;
        mx = 0;
        for (int i = 0; i < 4; i++)
        begin
            s      = 64'(qa[i]) * k0 + 64'(qb[i]) * k1;
            neg[i] = s < 0;
            mag[i] = neg[i] ? -s : s;
            if (mag[i] > mx)
                mx = mag[i];
        end
        o = '0;
        if (mx == 0)
        begin
            o.zero_norm = 1'b1;
            return o;
        end
        while (mx > (64'd1 << 31))
        begin
            mx = mx >> 1;
            for (int i = 0; i < 4; i++)
                mag[i] = mag[i] >> 1;
        end
        while (mx <= (64'd1 << 30))
        begin
            mx = mx << 1;
            for (int i = 0; i < 4; i++)
                mag[i] = mag[i] << 1;
        end
        q = 0;
        for (int i = 0; i < 4; i++)
            q += (mag[i] * mag[i]) >> 2;
        r = root_floor(q);
        for (int i = 0; i < 4; i++)
        begin
            om = (mag[i] * (64'd1 << (CW - 2)) + (r >> 1)) / r;
            if (om > (64'd1 << (CW - 1)))
                om = 64'd1 << (CW - 1);
            v = neg[i] ? -$signed(om) : $signed(om);
            // exact +1.0 saturates to the largest positive code
            if (v > (2**(CW-1)) - 1)
                v = (2**(CW-1)) - 1;
            if (v < -(2**(CW-1)))
                v = -(2**(CW-1));
            res[i] = comp_t'(v);
        end
        o.w = res[0];
        o.x = res[1];
        o.y = res[2];
        o.z = res[3];
        return o;
    endfunction

    // drive one beat and wait for its handshake, valid stays up for a following beat
    task automatic send_blend(input comp_t qa[4], input comp_t qb[4],
                              input logic [BLEND_W-1:0] t_raw);
        logic [IN_W-1:0] d;
        d = '0;
        for (int i = 0; i < 4; i++)
        begin
            d[i*CW +: CW]     = qa[i];
            d[(4+i)*CW +: CW] = qb[i];
        end
        d[8*CW +: BLEND_W] = t_raw;
        while (send_gaps && $urandom_range(99) < 8)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_blends.push_back(predict_nlerp(qa, qb, t_raw));
        @(negedge clk);
    endtask

    function automatic comp_t rand_comp();
        case ($urandom_range(9))
            0: return comp_t'(16'h8000);
            1: return comp_t'(16'h7fff);
            2: return comp_t'($urandom_range(7)) - 3;
            default: return comp_t'($urandom);
        endcase
    endfunction

    function automatic logic [BLEND_W-1:0] rand_blend();
        case ($urandom_range(9))
            0: return 0;
            1: return ONE_Q16;
            2: return BLEND_W'($urandom_range(131071, 65537));
            default: return BLEND_W'($urandom_range(65536));
        endcase
    endfunction

    task automatic send_random(input int n);
        comp_t qa[4], qb[4];
        for (int k = 0; k < n; k++)
        begin
            for (int i = 0; i < 4; i++)
            begin
                qa[i] = rand_comp();
                qb[i] = ($urandom_range(9) == 0) ? -qa[i] :
                        ($urandom_range(9) == 0) ? qa[i] : rand_comp();
            end
            send_blend(qa, qb, rand_blend());
        end
    endtask

    // drop valid and wait until every expected beat has come out
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending_blends.size() != 0)
            @(negedge clk);
    endtask

    // extremes, zero dot, opposite quaternions, blend saturation, unit result
    task automatic test_directed();
        comp_t qa[4], qb[4];
        qa = '{16'sh7fff, 0, 0, 0};  qb = '{0, 16'sh7fff, 0, 0};
        send_blend(qa, qb, 0);
        send_blend(qa, qb, ONE_Q16);
        send_blend(qa, qb, 17'h8000);           // zero dot, k1 negated
        send_blend(qa, qb, 17'h1ffff);          // blend above one
        qa = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff};
        qb = qa;
        send_blend(qa, qb, 17'h4000);
        qb = '{-16'sh7fff, -16'sh7fff, -16'sh7fff, -16'sh7fff};
        send_blend(qa, qb, 17'h8000);           // negative dot
        qa = '{-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000};
        qb = qa;
        send_blend(qa, qb, 17'h10000);
        send_blend(qa, qb, 17'h0);
        qa = '{0, 0, 0, 0};  qb = qa;
        send_blend(qa, qb, 17'h1234);           // zero norm
        qa = '{16'sh4000, 0, 0, 0};  qb = '{16'shc000, 0, 0, 0};
        send_blend(qa, qb, 17'h8000);           // dot negative, still unit
        qa = '{1, 0, 0, 0};  qb = '{0, 0, 0, 1};
        send_blend(qa, qb, 17'h1);
        qa = '{-16'sh8000, 0, 0, 0};
        send_blend(qa, qb, 17'h0);              // exact -1.0
        qa = '{16'sh5555, -16'sh2aaa, 16'sh1111, -16'sh0001};
        qb = '{-16'sh1234, 16'sh7654, -16'sh0f0f, 16'sh00ff};
        send_blend(qa, qb, 17'hffff);
        send_blend(qa, qb, 17'h00001);
        wait_drained();
    endtask

    // full rate both sides
    task automatic test_back_to_back();
        send_gaps = 0;
        recv_gaps = 0;
        send_random(150);
        send_gaps = 1;
        recv_gaps = 1;
    endtask

    // long receiver hold-off so the pipeline fills and stalls its input
    task automatic test_backpressure();
        hold_off = 3 * LAT;
        send_random(120);
    endtask

    // sender pauses until everything drains, then resumes
    task automatic test_drain_pause();
        send_random(40);
        wait_drained();
        send_random(40);
    endtask

    // random gaps on both sides
    task automatic test_random_blends();
        send_random(200);
    endtask

    // receiver side: stalls and the hold-off counter
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off > 0)
            begin
                hold_off--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= !(recv_gaps && $urandom_range(99) < 8);
        end
    end

    // compare each accepted result beat with the oldest expectation
    initial
    begin
        blend_out_t want, got;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                got.w         = m_tdata[0*CW +: CW];
                got.x         = m_tdata[1*CW +: CW];
                got.y         = m_tdata[2*CW +: CW];
                got.z         = m_tdata[3*CW +: CW];
                got.zero_norm = m_tuser;
                if (pending_blends.size() == 0)
                begin
                    $display("%0t: unexpected beat %h", $realtime, got);
                    errors++;
                end
                else
                begin
                    want = pending_blends.pop_front();
                    if (got.w !== want.w || got.x !== want.x || got.y !== want.y ||
                        got.z !== want.z || got.zero_norm !== want.zero_norm)
                    begin
                        $display("%0t: mismatch expected w=%0d x=%0d y=%0d z=%0d zn=%0b",
                                 $realtime, want.w, want.x, want.y, want.z, want.zero_norm);
                        $display("%0t:          actual   w=%0d x=%0d y=%0d z=%0d zn=%0b",
                                 $realtime, got.w, got.x, got.y, got.z, got.zero_norm);
                        errors++;
                    end
                end
            end
        end
    end

    initial
    begin
        errors    = 0;
        send_gaps = 1;
        recv_gaps = 1;
        hold_off  = 0;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_back_to_back();
        test_backpressure();
        test_drain_pause();
        test_random_blends();
        wait_drained();
        repeat (2 * LAT) @(negedge clk);
        if (errors == 0 && pending_blends.size() == 0)
            $display("PASS quaternion_nlerp");
        else
            $display("FAIL quaternion_nlerp");
        $finish;
    end

endmodule

### files.f
design/qnl_pkg.sv
design/qnl_front.sv
design/qnl_norm.sv
design/qnl_sqrt.sv
design/qnl_div.sv
design/quaternion_nlerp.sv
tb/sv/quaternion_nlerp_tb.sv
